[sv/log_record_deframer_assert.svh]
// ----------------------------------------------------------------------------
// log_record_deframer_assert.svh
// Assertion macros used by the deframer checker lrd_checker.
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_DEFRAMER_ASSERT_SVH
`define LOG_RECORD_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define LRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

[sv/lrd_pkg.sv]
// ----------------------------------------------------------------------------
// lrd_pkg
// Types and constants of the log record deframer.
// ----------------------------------------------------------------------------
package lrd_pkg;

    localparam int MARKER_BYTES_DEF = 8;
    localparam int KEY_BYTES        = 80;

    localparam logic [3:0]  NIBBLE_MAX    = 4'd1;
    localparam logic [15:0] MAX_LEN_RESET = 16'd16384;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_MARKER_PATTERN = 2'd0;
    localparam cfg_index_t REG_MAX_LOG_LENGTH = 2'd1;

    typedef enum logic [2:0] {
        PH_MODE,
        PH_KEY,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_MARKER,
        PH_HUNT
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_BAD_MODE,
        EV_BAD_LENGTH,
        EV_BAD_MARKER,
        EV_RESYNC
    } event_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_region;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        record_done;
        logic [15:0] record_length;
        logic [31:0] log_count;
        logic [39:0] total_payload;
        event_t      event_code;
        logic        region_done;
    } result_t;

    typedef struct packed {
        logic [63:0] marker_pattern;
        logic [15:0] max_log_length;
    } cfg_t;

endpackage

[sv/lrd_in_if.sv]
// ----------------------------------------------------------------------------
// lrd_in_if
// Byte channel into the deframer.
// ----------------------------------------------------------------------------
interface lrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_region;
    logic       last_byte;

    modport source (output valid, output data_byte, output start_of_region,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input start_of_region,
                    input last_byte, output ready);
    modport monitor (input valid, input ready, input data_byte,
                     input start_of_region, input last_byte);
endinterface

[sv/lrd_out_if.sv]
// ----------------------------------------------------------------------------
// lrd_out_if
// Per-byte result channel out of the deframer.
// ----------------------------------------------------------------------------
interface lrd_out_if;
    logic        valid;
    logic        ready;
    logic        record_done;
    logic [15:0] record_length;
    logic [31:0] log_count;
    logic [39:0] total_payload;
    logic [2:0]  event_code;
    logic        region_done;

    modport source (output valid, output record_done, output record_length,
                    output log_count, output total_payload, output event_code,
                    output region_done, input ready);
    modport sink   (input valid, input record_done, input record_length,
                    input log_count, input total_payload, input event_code,
                    input region_done, output ready);
    modport monitor (input valid, input ready, input record_done,
                     input record_length, input log_count, input total_payload,
                     input event_code, input region_done);
endinterface

[sv/lrd_cfg_if.sv]
// ----------------------------------------------------------------------------
// lrd_cfg_if
// Register write channel of the deframer.
// ----------------------------------------------------------------------------
interface lrd_cfg_if;
    logic                valid;
    logic                ready;
    lrd_pkg::cfg_index_t index;
    logic [63:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
    modport monitor (input valid, input ready, input index, input data);
endinterface

[sv/lrd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lrd_cfg_regs
// Configuration registers: sync marker and maximum payload length.
// ----------------------------------------------------------------------------
module lrd_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  lrd_pkg::cfg_index_t wr_index,
    input  logic [63:0]         wr_data,
    output lrd_pkg::cfg_t       cfg
);

    logic [63:0] marker_reg;
    logic [15:0] max_len_reg;

    assign wr_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg  <= '0;
            max_len_reg <= lrd_pkg::MAX_LEN_RESET;
        end
        else if (wr_valid)
        begin
            case (wr_index)
                lrd_pkg::REG_MARKER_PATTERN: marker_reg  <= wr_data;
                lrd_pkg::REG_MAX_LOG_LENGTH: max_len_reg <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.marker_pattern = marker_reg;
    assign cfg.max_log_length = max_len_reg;

endmodule

[sv/lrd_parser.sv]
// ----------------------------------------------------------------------------
// lrd_parser
// Input register, parse state and the per-byte next-state logic.
// ----------------------------------------------------------------------------
module lrd_parser
#(
    parameter int MARKER_BYTES = lrd_pkg::MARKER_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lrd_pkg::in_item_t in_item,
    input  lrd_pkg::cfg_t     cfg,
    output logic              res_valid,
    input  logic              res_ready,
    output lrd_pkg::result_t  res
);

    localparam int WIN_W  = 8 * MARKER_BYTES;
    localparam int FILL_W = $clog2(MARKER_BYTES + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MARKER_BYTES);
    localparam logic [6:0]        KEY_LAST  = 7'(lrd_pkg::KEY_BYTES);

    logic              valid_reg;
    lrd_pkg::in_item_t item_reg;
    logic              fire;

    lrd_pkg::phase_t    phase_reg, phase_next, phase_cur;
    logic [6:0]         fc_reg, fc_next, fc_cur;
    logic [15:0]        len_reg, len_next, len_cur;
    logic [15:0]        left_reg, left_next, left_cur;
    logic [WIN_W-1:0]   win_reg, win_next, win_cur, win_sh;
    logic [FILL_W-1:0]  fill_reg, fill_next, fill_cur, fill_sh;
    logic [31:0]        count_reg, count_next, count_cur;
    logic [39:0]        sum_reg, sum_next, sum_cur;
    logic [40:0]        sum_wide;
    logic [15:0]        len_full;
    logic [15:0]        left_dec;
    logic [7:0]         b;
    logic               clr, full_sh, match_sh, done;
    lrd_pkg::event_t    ev;

    assign in_ready  = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign fire      = valid_reg && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    always_comb
    begin
        b   = item_reg.data_byte;
        clr = item_reg.start_of_region;

        // start of region clears parser and counters before this byte
        phase_cur = clr ? lrd_pkg::PH_MODE : phase_reg;
        fc_cur    = clr ? '0 : fc_reg;
        len_cur   = clr ? '0 : len_reg;
        left_cur  = clr ? '0 : left_reg;
        win_cur   = clr ? '0 : win_reg;
        fill_cur  = clr ? '0 : fill_reg;
        count_cur = clr ? '0 : count_reg;
        sum_cur   = clr ? '0 : sum_reg;

        win_sh   = {b, win_cur[WIN_W-1:8]};
        fill_sh  = (fill_cur < FILL_FULL) ? fill_cur + FILL_W'(1) : fill_cur;
        full_sh  = fill_sh >= FILL_FULL;
        match_sh = full_sh && (win_sh == cfg.marker_pattern[WIN_W-1:0]);
        len_full = {b, len_cur[7:0]};
        left_dec = (left_cur != '0) ? left_cur - 16'd1 : left_cur;
        sum_wide = {1'b0, sum_cur} + 41'(len_cur);

        phase_next = phase_cur;
        fc_next    = fc_cur;
        len_next   = len_cur;
        left_next  = left_cur;
        win_next   = win_cur;
        fill_next  = fill_cur;
        count_next = count_cur;
        sum_next   = sum_cur;
        done       = 1'b0;
        ev         = lrd_pkg::EV_NONE;

        case (phase_cur)
            lrd_pkg::PH_MODE:
            begin
                if (b[7:4] > lrd_pkg::NIBBLE_MAX || b[3:0] > lrd_pkg::NIBBLE_MAX)
                begin
                    ev         = lrd_pkg::EV_BAD_MODE;
                    phase_next = lrd_pkg::PH_HUNT;
                    win_next   = '0;
                    fill_next  = '0;
                end
                else
                begin
                    fc_next    = '0;
                    phase_next = b[0] ? lrd_pkg::PH_KEY : lrd_pkg::PH_LEN_LO;
                end
            end
            lrd_pkg::PH_KEY:
            begin
                fc_next = fc_cur + 7'd1;
                if (fc_next >= KEY_LAST)
                begin
                    fc_next    = '0;
                    phase_next = lrd_pkg::PH_LEN_LO;
                end
            end
            lrd_pkg::PH_LEN_LO:
            begin
                len_next   = {8'd0, b};
                phase_next = lrd_pkg::PH_LEN_HI;
            end
            lrd_pkg::PH_LEN_HI:
            begin
                len_next = len_full;
                if (len_full == '0 || len_full > cfg.max_log_length)
                begin
                    ev         = lrd_pkg::EV_BAD_LENGTH;
                    phase_next = lrd_pkg::PH_HUNT;
                    win_next   = '0;
                    fill_next  = '0;
                end
                else
                begin
                    left_next  = len_full;
                    phase_next = lrd_pkg::PH_PAYLOAD;
                end
            end
            lrd_pkg::PH_PAYLOAD:
            begin
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = lrd_pkg::PH_MARKER;
                    win_next   = '0;
                    fill_next  = '0;
                end
            end
            lrd_pkg::PH_MARKER:
            begin
                win_next  = win_sh;
                fill_next = fill_sh;
                if (full_sh)
                begin
                    if (match_sh)
                    begin
                        done       = 1'b1;
                        count_next = (count_cur == '1) ? count_cur : count_cur + 32'd1;
                        sum_next   = sum_wide[40] ? '1 : sum_wide[39:0];
                        phase_next = lrd_pkg::PH_MODE;
                    end
                    else
                    begin
                        ev         = lrd_pkg::EV_BAD_MARKER;
                        phase_next = lrd_pkg::PH_HUNT;
                        win_next   = '0;
                        fill_next  = '0;
                    end
                end
            end
            default:
            begin
                // hunting: slide the window until it holds the marker
                win_next  = win_sh;
                fill_next = fill_sh;
                if (match_sh)
                begin
                    ev         = lrd_pkg::EV_RESYNC;
                    phase_next = lrd_pkg::PH_MODE;
                end
            end
        endcase

        res.record_done   = done;
        res.record_length = done ? len_cur : '0;
        res.log_count     = count_next;
        res.total_payload = sum_next;
        res.event_code    = ev;
        res.region_done   = item_reg.last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lrd_pkg::PH_MODE;
            fc_reg    <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            win_reg   <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

[sv/lrd_out_stage.sv]
// ----------------------------------------------------------------------------
// lrd_out_stage
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module lrd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  lrd_pkg::result_t up_data,
    output logic             dn_valid,
    input  logic             dn_ready,
    output lrd_pkg::result_t dn_data
);

    logic             valid_reg;
    lrd_pkg::result_t data_reg;

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= up_data;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[sv/log_record_deframer.sv]
// ----------------------------------------------------------------------------
// log_record_deframer
// Byte-serial parser of the record area of a log file.
// ----------------------------------------------------------------------------
// byte_chan carries one byte per transfer with start_of_region and last_byte
// flags; result_chan returns exactly one result per byte: record completion,
// its length, running saturating record and payload counts, an event code and
// an echo of last_byte. cfg_chan writes the sync marker (index 0) and the
// maximum payload length (index 1); it is always ready and is meant to be
// written while the block is idle.
// Throughput is one byte per cycle while result_chan is ready. A byte is held in
// the input register, where the parse state and the counters are updated in a
// single pass, and moves on to the result register, which drives result_chan.
// Reset clears the parser to expect a mode byte, zeroes the counters, sets the
// marker to zero and the maximum length to 16384. A stalled result holds in
// the result register while one more byte is still taken into the input
// register; after that byte_chan.ready drops until result_chan drains.
// ----------------------------------------------------------------------------
module log_record_deframer
#(
    parameter int MARKER_BYTES = lrd_pkg::MARKER_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    lrd_in_if.sink    byte_chan,
    lrd_out_if.source result_chan,
    lrd_cfg_if.sink   cfg_chan
);

    lrd_pkg::cfg_t     cfg;
    lrd_pkg::in_item_t in_item;
    lrd_pkg::result_t  parse_res;
    lrd_pkg::result_t  out_res;
    logic              parse_valid;
    logic              parse_ready;

    assign in_item.data_byte       = byte_chan.data_byte;
    assign in_item.start_of_region = byte_chan.start_of_region;
    assign in_item.last_byte       = byte_chan.last_byte;

    lrd_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg_chan.valid),
        .wr_ready (cfg_chan.ready),
        .wr_index (cfg_chan.index),
        .wr_data  (cfg_chan.data),
        .cfg      (cfg)
    );

    lrd_parser #(.MARKER_BYTES(MARKER_BYTES)) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_chan.valid),
        .in_ready  (byte_chan.ready),
        .in_item   (in_item),
        .cfg       (cfg),
        .res_valid (parse_valid),
        .res_ready (parse_ready),
        .res       (parse_res)
    );

    lrd_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (parse_valid),
        .up_ready (parse_ready),
        .up_data  (parse_res),
        .dn_valid (result_chan.valid),
        .dn_ready (result_chan.ready),
        .dn_data  (out_res)
    );

    assign result_chan.record_done   = out_res.record_done;
    assign result_chan.record_length = out_res.record_length;
    assign result_chan.log_count     = out_res.log_count;
    assign result_chan.total_payload = out_res.total_payload;
    assign result_chan.event_code    = out_res.event_code;
    assign result_chan.region_done   = out_res.region_done;

endmodule

[sv/lrd_checker.sv]
// ----------------------------------------------------------------------------
// lrd_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
`include "log_record_deframer_assert.svh"

module lrd_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic        res_done,
    input  logic [15:0] res_length,
    input  logic [31:0] res_count,
    input  logic [39:0] res_total,
    input  logic [2:0]  res_event
);

    logic stalled;
    logic done_out;

    assign stalled  = res_valid && !res_ready;
    assign done_out = res_valid && res_done;

    `LRD_ASSERT_NEXT(a_hold, clk, rst_n, stalled, res_valid && $stable({res_count, res_total, res_event}))
    `LRD_ASSERT_NOW(a_done_no_event, clk, rst_n, done_out, res_event == 3'd0 && res_length != 16'd0)
    `LRD_ASSERT_NOW(a_len_only_on_done, clk, rst_n, res_valid && !res_done, res_length == 16'd0)
    `LRD_ASSERT_NOW(a_done_counted, clk, rst_n, done_out, res_count != 32'd0 && res_total != 40'd0)

endmodule

bind log_record_deframer lrd_checker u_lrd_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result_chan.valid),
    .res_ready  (result_chan.ready),
    .res_done   (result_chan.record_done),
    .res_length (result_chan.record_length),
    .res_count  (result_chan.log_count),
    .res_total  (result_chan.total_payload),
    .res_event  (result_chan.event_code)
);

[tb/log_record_deframer_test.sv]
// ----------------------------------------------------------------------------
// log_record_deframer_test
// Self-checking bench for the byte-serial log record deframer.
// ----------------------------------------------------------------------------
// Streams the record area into the block one byte per transfer and compares
// every per-byte result against an in-bench parser model. Directed records
// come first and cover the reset register values and each error event. Random
// record streams follow: well-formed records with random content make up most
// of them, and damaged mode bytes, lengths and markers, cut regions and noise
// make up the rest. The sender idles in bursts and the receiver stalls on
// changing patterns. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module log_record_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lrd_pkg::*;

    localparam int          MARKER_LEN      = MARKER_BYTES_DEF;
    localparam logic [63:0] MARKER_MASK     = {64{1'b1}} >> (64 - 8 * MARKER_LEN);
    localparam logic [39:0] PAYLOAD_SUM_MAX = {40{1'b1}};
    localparam int          CYCLE_LIMIT     = 400000;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_PERIODIC,
        RX_HOLD
    } rx_pattern_t;

    logic clk = 1'b0;
    logic rst_n;

    lrd_in_if  byte_if();
    lrd_out_if result_if();
    lrd_cfg_if cfg_if();

    log_record_deframer u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_if),
        .result_chan (result_if),
        .cfg_chan    (cfg_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // parser model state, reset values
    phase_t      pstate      = PH_MODE;
    logic [6:0]  key_idx     = '0;
    logic        has_key     = 1'b0;
    logic [15:0] rec_len     = '0;
    logic [15:0] bytes_left  = '0;
    logic [63:0] win         = '0;
    logic [3:0]  win_fill    = '0;
    logic [31:0] rec_total   = '0;
    logic [39:0] byte_total  = '0;
    logic [63:0] cur_marker  = '0;
    logic [15:0] cur_max_len = MAX_LEN_RESET;

    result_t expected_results[$];

    int  mismatches    = 0;
    int  bytes_sent    = 0;
    int  records_done  = 0;
    int  settings_used = 1;
    int  event_tally[5] = '{default: 0};
    int  cycle_count   = 0;
    int  burst_left    = 0;
    bit  gaps_on       = 1'b1;

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    function automatic void open_window(phase_t nxt);
        pstate   = nxt;
        win      = '0;
        win_fill = '0;
    endfunction

    // true once the window is full and equals the marker
    function automatic logic shift_window(logic [7:0] b);
        win = ((win >> 8) | ({56'd0, b} << (8 * (MARKER_LEN - 1)))) & MARKER_MASK;
        if (win_fill < MARKER_LEN)
            win_fill = win_fill + 4'd1;
        return (win_fill >= MARKER_LEN) && (win == (cur_marker & MARKER_MASK));
    endfunction

    function automatic result_t deframe_byte(logic [7:0] b, logic sor, logic last);
        result_t     r;
        logic [40:0] pay_sum_next;
        r = '0;
        if (sor)
        begin
            open_window(PH_MODE);
            key_idx    = '0;
            has_key    = 1'b0;
            rec_len    = '0;
            bytes_left = '0;
            rec_total  = '0;
            byte_total = '0;
        end
        case (pstate)
            PH_MODE:
            begin
                if (b[7:4] > NIBBLE_MAX || b[3:0] > NIBBLE_MAX)
                begin
                    r.event_code = EV_BAD_MODE;
                    open_window(PH_HUNT);
                end
                else
                begin
                    has_key = b[0];
                    key_idx = '0;
                    pstate  = has_key ? PH_KEY : PH_LEN_LO;
                end
            end
            PH_KEY:
            begin
                key_idx = key_idx + 7'd1;
                if (key_idx >= KEY_BYTES)
                begin
                    key_idx = '0;
                    pstate  = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                rec_len = {8'h00, b};
                pstate  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                rec_len = {b, rec_len[7:0]};
                if (rec_len == 16'd0 || rec_len > cur_max_len)
                begin
                    r.event_code = EV_BAD_LENGTH;
                    open_window(PH_HUNT);
                end
                else
                begin
                    bytes_left = rec_len;
                    pstate     = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (bytes_left != 16'd0)
                    bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                    open_window(PH_MARKER);
            end
            PH_MARKER:
            begin
                if (shift_window(b))
                begin
                    r.record_done   = 1'b1;
                    r.record_length = rec_len;
                    if (rec_total != 32'hFFFF_FFFF)
                        rec_total = rec_total + 32'd1;
                    pay_sum_next = {1'b0, byte_total} + rec_len;
                    byte_total = (pay_sum_next > PAYLOAD_SUM_MAX) ? PAYLOAD_SUM_MAX
                                                                  : pay_sum_next[39:0];
                    pstate = PH_MODE;
                end
                else if (win_fill >= MARKER_LEN)
                begin
                    r.event_code = EV_BAD_MARKER;
                    open_window(PH_HUNT);
                end
            end
            default:
            begin
                if (shift_window(b))
                begin
                    r.event_code = EV_RESYNC;
                    pstate       = PH_MODE;
                end
            end
        endcase
        r.log_count     = rec_total;
        r.total_payload = byte_total;
        r.region_done   = last;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // byte monitor feeds the model, result monitor checks in order
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
        else if (rst_n)
        begin
            if (byte_if.valid && byte_if.ready)
            begin
                want = deframe_byte(byte_if.data_byte, byte_if.start_of_region,
                                    byte_if.last_byte);
                if (want.record_done)
                    records_done++;
                event_tally[want.event_code]++;
                expected_results.push_back(want);
            end
            if (result_if.valid && result_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no byte outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("record_done", want.record_done, result_if.record_done);
                    check_field("record_length", want.record_length,
                                result_if.record_length);
                    check_field("log_count", want.log_count, result_if.log_count);
                    check_field("total_payload", want.total_payload,
                                result_if.total_payload);
                    check_field("event_code", want.event_code, result_if.event_code);
                    check_field("region_done", want.region_done, result_if.region_done);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result backpressure in randomly chosen, changing patterns
    // ------------------------------------------------------------------------
    initial
    begin : rx_stall
        rx_pattern_t rx_pattern;
        int          pattern_left;
        int          hold_left;
        int          rx_tick;
        rx_pattern   = RX_STREAM;
        pattern_left = 0;
        hold_left    = 0;
        rx_tick      = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pattern_left == 0)
            begin
                rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            rx_tick++;
            case (rx_pattern)
                RX_STREAM:   result_if.ready <= 1'b1;
                RX_RANDOM:   result_if.ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: result_if.ready <= ((rx_tick % 5) < 3);
                default:
                begin
                    if (hold_left != 0)
                    begin
                        hold_left--;
                        result_if.ready <= 1'b0;
                    end
                    else
                    begin
                        result_if.ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            hold_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic sor, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                byte_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        byte_if.valid           <= 1'b1;
        byte_if.data_byte       <= b;
        byte_if.start_of_region <= sor;
        byte_if.last_byte       <= last;
        do @(posedge clk); while (!byte_if.ready);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] mode, input logic [15:0] len,
                               input logic sor);
        send_byte(mode, sor, 1'b0);
        if (mode[0])
            repeat (KEY_BYTES) send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(len[7:0], 1'b0, 1'b0);
        send_byte(len[15:8], 1'b0, 1'b0);
    endtask

    task automatic send_payload(input int n);
        repeat (n) send_byte(8'($urandom), 1'b0, 1'b0);
    endtask

    task automatic send_marker(input logic [63:0] m, input logic last);
        for (int i = 0; i < MARKER_LEN; i++)
            send_byte(m[8 * i +: 8], 1'b0, last && (i == MARKER_LEN - 1));
    endtask

    // a few stray bytes, then the marker to end the hunt
    task automatic resync();
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
        send_marker(cur_marker, $urandom_range(0, 7) == 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        if (idx == REG_MARKER_PATTERN)
            cur_marker = value;
        else
            cur_max_len = value[15:0];
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        @(negedge clk);
        byte_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int pick_length();
        int top;
        top = (cur_max_len < 12) ? int'(cur_max_len) : 12;
        if ($urandom_range(0, 19) == 0)
            return (cur_max_len < 160) ? int'(cur_max_len) : 160;
        return $urandom_range(1, top);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: zero marker, max length 16384
    task automatic test_reset_config();
        send_header(8'h00, 16'h0001, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_marker(64'd0, 1'b1);
        // parse continues past last_byte; 16385 is one above the reset max
        send_header(8'h00, 16'h4001, 1'b0);
        send_marker(64'd0, 1'b0);
    endtask

    task automatic test_field_errors();
        logic [63:0] damaged;
        send_byte(8'hF2, 1'b1, 1'b0);
        send_marker(cur_marker, 1'b0);
        send_header(8'h10, 16'h0000, 1'b0);
        send_marker(cur_marker, 1'b0);
        damaged = cur_marker ^ (64'h80 << 56);
        send_header(8'h00, 16'h0001, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_marker(damaged, 1'b0);
        send_marker(cur_marker, 1'b1);
    endtask

    task automatic test_record_stream(input int target);
        int          first;
        int          pick;
        int          len;
        int          cut;
        logic [7:0]  mode;
        logic [63:0] damaged;
        logic        sor_next;
        first    = bytes_sent;
        sor_next = 1'b1;
        while (bytes_sent - first < target)
        begin
            if ($urandom_range(0, 15) == 0)
                gaps_on = !gaps_on;
            pick    = $urandom_range(0, 99);
            len     = pick_length();
            mode    = 8'h00;
            mode[4] = 1'($urandom_range(0, 1));
            mode[0] = ($urandom_range(0, 7) == 0);
            if (pick < 55)
            begin
                send_header(mode, 16'(len), sor_next);
                send_payload(len);
                send_marker(cur_marker, $urandom_range(0, 9) == 0);
                sor_next = ($urandom_range(0, 9) == 0);
            end
            else if (pick < 65)
            begin
                // mode byte with at least one nibble out of range
                mode = 8'($urandom);
                if ($urandom_range(0, 1) != 0)
                    mode[7:4] = 4'($urandom_range(2, 15));
                else
                    mode[3:0] = 4'($urandom_range(2, 15));
                send_byte(mode, sor_next, 1'b0);
                sor_next = 1'b0;
                resync();
            end
            else if (pick < 75)
            begin
                if (cur_max_len == 16'hFFFF || $urandom_range(0, 3) == 0)
                    len = 0;
                else
                    len = $urandom_range(int'(cur_max_len) + 1, 65535);
                send_header(mode, 16'(len), sor_next);
                sor_next = 1'b0;
                resync();
            end
            else if (pick < 85)
            begin
                damaged = cur_marker;
                damaged[8 * $urandom_range(0, MARKER_LEN - 1) +: 8] ^= 8'($urandom_range(1, 255));
                send_header(mode, 16'(len), sor_next);
                sor_next = 1'b0;
                send_payload(len);
                send_marker(damaged, 1'b0);
                resync();
            end
            else if (pick < 93)
            begin
                // region ends inside the payload, next region restarts
                cut = $urandom_range(1, len);
                send_header(mode, 16'(len), sor_next);
                send_payload(cut - 1);
                send_byte(8'($urandom), 1'b0, 1'b1);
                sor_next = 1'b1;
            end
            else
            begin
                send_byte(8'($urandom), sor_next, 1'b0);
                repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0, 1'b0);
                sor_next = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        byte_if.valid           = 1'b0;
        byte_if.data_byte       = 8'h00;
        byte_if.start_of_region = 1'b0;
        byte_if.last_byte       = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = REG_MARKER_PATTERN;
        cfg_if.data             = 64'd0;
        rst_n                   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_config();
        drain();

        write_reg(REG_MARKER_PATTERN, {64{1'b1}});
        write_reg(REG_MAX_LOG_LENGTH, 64'hFFFF);
        settings_used++;
        test_field_errors();
        drain();

        for (int setting = 0; setting < 4; setting++)
        begin
            write_reg(REG_MARKER_PATTERN, {32'($urandom), 32'($urandom)});
            case (setting)
                0:       write_reg(REG_MAX_LOG_LENGTH, 64'd24);
                1:       write_reg(REG_MAX_LOG_LENGTH, 64'hFFFF);
                2:       write_reg(REG_MAX_LOG_LENGTH, 64'd1);
                default: write_reg(REG_MAX_LOG_LENGTH, 64'($urandom_range(1, 40)));
            endcase
            settings_used++;
            test_record_stream(100);
            drain();
        end

        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatches++;
        end
        $display("%0d bytes over %0d register settings, %0d records completed",
                 bytes_sent, settings_used, records_done);
        $display("events: %0d bad mode, %0d bad length, %0d bad marker, %0d resync",
                 event_tally[EV_BAD_MODE], event_tally[EV_BAD_LENGTH],
                 event_tally[EV_BAD_MARKER], event_tally[EV_RESYNC]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
